// ===== rtl/latency_running_statistics_top_macros.svh =====
// Assertion macros used by the checker of the latency statistics block.
`ifndef LATENCY_RUNNING_STATISTICS_TOP_MACROS_SVH
`define LATENCY_RUNNING_STATISTICS_TOP_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define LRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies another one on the next rising aclk edge.
`define LRS_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== rtl/lrs_pkg.sv =====
// Shared widths, step counts and controller/datapath signal bundles.
package lrs_pkg;

    localparam int unsigned RttW   = 32;
    localparam int unsigned CountW = 32;
    localparam int unsigned MeanW  = 48;
    localparam int unsigned SumW   = 64;
    localparam int unsigned FracW  = MeanW - RttW;
    localparam int unsigned HalfW  = MeanW / 2;
    localparam int unsigned ProdW  = 2 * MeanW;
    localparam int unsigned DivSteps = MeanW;
    localparam int unsigned StepW  = $clog2(DivSteps);
    localparam int unsigned MulSteps = 4;

    typedef struct packed {
        logic start;      // load sample, update count/min/max, set up division
        logic div_step;   // one restoring-division bit
        logic mean_step;  // commit new mean, form post-update deviation
        logic mul_step;   // one partial product of the deviation product
        logic finish;     // commit squared-deviation sum, load result
    } lrs_cmd_t;

    typedef struct packed {
        logic div_last;
        logic mul_last;
    } lrs_status_t;

endpackage

// ===== rtl/latency_running_statistics_top.sv =====
// Top level of the running latency statistics block (Welford mean and variance).
// A sample passes through 48 divider steps, 1 mean update, 4 partial products and 1 result
// load before its result is valid, and waits longer while the result register is full.
// A new sample is taken only once the result of the previous one is loaded.
// Reset: synchronous, active low; count, max, mean and sum clear, min goes to all ones.
module latency_running_statistics_top
    import lrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // sample channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [RttW-1:0]   s_rtt_ns,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CountW-1:0] m_sample_count,
    output logic [RttW-1:0]   m_min_rtt_ns,
    output logic [RttW-1:0]   m_max_rtt_ns,
    output logic [MeanW-1:0]  m_mean_rtt_q16,
    output logic [SumW-1:0]   m_sum_sq_dev
);

    // Command and status bundles between the sequencer and the datapath.
    lrs_cmd_t    cmd;
    lrs_status_t sts;

    // Sequencer: accepts a sample transfer only when idle, steps the divider
    // and the multiplier, and loads the result register once it is free, so a
    // finished result may wait downstream while the next sample is taken.
    lrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: count, min and max update at the transfer; the mean moves by
    // delta / count (truncating toward zero) after the serial division; the
    // deviation product is built from 24x24 partial products, scaled by 2^-32
    // and, unless it is negative, added to the saturating sum as the result is loaded.
    lrs_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .rtt_ns       (s_rtt_ns),
        .sample_count (m_sample_count),
        .min_rtt_ns   (m_min_rtt_ns),
        .max_rtt_ns   (m_max_rtt_ns),
        .mean_rtt_q16 (m_mean_rtt_q16),
        .sum_sq_dev   (m_sum_sq_dev)
    );

endmodule

// ===== rtl/lrs_ctrl.sv =====
// Controller state machine: sequences division, mean update, multiply and result.
module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  lrs_status_t sts,
    output lrs_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MEAN = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                cmd.mean_step = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/lrs_datapath.sv =====
// Datapath: statistics registers, serial divider, split multiplier and result register.
module lrs_datapath
    import lrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lrs_cmd_t          cmd,
    output lrs_status_t       sts,
    input  logic [RttW-1:0]   rtt_ns,
    output logic [CountW-1:0] sample_count,
    output logic [RttW-1:0]   min_rtt_ns,
    output logic [RttW-1:0]   max_rtt_ns,
    output logic [MeanW-1:0]  mean_rtt_q16,
    output logic [SumW-1:0]   sum_sq_dev
);

    // statistics state
    logic [CountW-1:0] count_reg, count_next;
    logic [RttW-1:0]   min_reg, min_next;
    logic [RttW-1:0]   max_reg, max_next;
    logic [MeanW-1:0]  mean_reg, mean_next;
    logic [SumW-1:0]   sq_dev_reg, sq_dev_next;

    // per-item working registers
    logic [MeanW-1:0]  x_reg;
    logic [MeanW-1:0]  d_mag_reg;
    logic              d_neg_reg;
    logic [CountW-1:0] rem_reg;
    logic [MeanW-1:0]  quo_reg;
    logic [MeanW-1:0]  e_mag_reg;
    logic              add_en_reg;
    logic [ProdW-1:0]  acc_reg;
    logic [StepW-1:0]  step_reg, step_next;

    // result register
    logic [CountW-1:0] out_count_reg;
    logic [RttW-1:0]   out_min_reg;
    logic [RttW-1:0]   out_max_reg;
    logic [MeanW-1:0]  out_mean_reg;
    logic [SumW-1:0]   out_sum_reg;

    logic [MeanW-1:0]  x_in;
    logic              d_neg_in;
    logic [MeanW-1:0]  d_mag_in;
    logic [CountW:0]   shifted;
    logic [CountW:0]   trial;
    logic              trial_ge;
    logic              e_neg;
    logic [MeanW-1:0]  e_mag;
    logic [HalfW-1:0]  mul_a;
    logic [HalfW-1:0]  mul_b;
    logic [MeanW-1:0]  part;
    logic [ProdW-1:0]  part_ext;
    logic [ProdW-1:0]  part_sh;
    logic [SumW:0]     sum_wide;

    assign x_in     = {rtt_ns, {FracW{1'b0}}};
    assign d_neg_in = (x_in < mean_reg);
    assign d_mag_in = d_neg_in ? (mean_reg - x_in) : (x_in - mean_reg);

    always_comb begin
        count_next = (count_reg != {CountW{1'b1}}) ? (count_reg + 1'b1) : count_reg;
        min_next   = (rtt_ns < min_reg) ? rtt_ns : min_reg;
        max_next   = (rtt_ns > max_reg) ? rtt_ns : max_reg;
    end

    // restoring division, one quotient bit per cycle
    assign shifted  = {rem_reg, quo_reg[MeanW-1]};
    assign trial    = shifted - {1'b0, count_reg};
    assign trial_ge = !trial[CountW];

    assign mean_next = d_neg_reg ? (mean_reg - quo_reg) : (mean_reg + quo_reg);
    assign e_neg     = (x_reg < mean_next);
    assign e_mag     = e_neg ? (mean_next - x_reg) : (x_reg - mean_next);

    // 48x48 product as four 24x24 partial products
    assign mul_a    = step_reg[0] ? d_mag_reg[MeanW-1:HalfW] : d_mag_reg[HalfW-1:0];
    assign mul_b    = step_reg[1] ? e_mag_reg[MeanW-1:HalfW] : e_mag_reg[HalfW-1:0];
    assign part     = mul_a * mul_b;
    assign part_ext = {{(ProdW-MeanW){1'b0}}, part};

    always_comb begin
        case (step_reg[1:0])
            2'b00:   part_sh = part_ext;
            2'b11:   part_sh = part_ext << MeanW;
            default: part_sh = part_ext << HalfW;
        endcase
    end

    // drop the 32 fraction bits, then add with saturation
    assign sum_wide = {1'b0, sq_dev_reg} + {1'b0, acc_reg[ProdW-1:ProdW-SumW]};

    always_comb begin
        if (!add_en_reg) begin
            sq_dev_next = sq_dev_reg;
        end else if (sum_wide[SumW]) begin
            sq_dev_next = {SumW{1'b1}};
        end else begin
            sq_dev_next = sum_wide[SumW-1:0];
        end
    end

    always_comb begin
        step_next = step_reg;
        if (cmd.start || cmd.mean_step) begin
            step_next = '0;
        end else if (cmd.div_step || cmd.mul_step) begin
            step_next = step_reg + 1'b1;
        end
    end

    assign sts.div_last = (step_reg == StepW'(DivSteps - 1));
    assign sts.mul_last = (step_reg[1:0] == 2'(MulSteps - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            min_reg    <= {RttW{1'b1}};
            max_reg    <= '0;
            mean_reg   <= '0;
            sq_dev_reg <= '0;
            step_reg   <= '0;
        end else begin
            step_reg <= step_next;
            if (cmd.start) begin
                count_reg <= count_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
            end
            if (cmd.mean_step) begin
                mean_reg <= mean_next;
            end
            if (cmd.finish) begin
                sq_dev_reg <= sq_dev_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg     <= x_in;
            d_neg_reg <= d_neg_in;
            d_mag_reg <= d_mag_in;
            quo_reg   <= d_mag_in;
            rem_reg   <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial[CountW-1:0] : shifted[CountW-1:0];
            quo_reg <= {quo_reg[MeanW-2:0], trial_ge};
        end
        if (cmd.mean_step) begin
            e_mag_reg  <= e_mag;
            add_en_reg <= (d_neg_reg == e_neg) || (d_mag_reg == '0) || (e_mag == '0);
            acc_reg    <= '0;
        end
        if (cmd.mul_step) begin
            acc_reg <= acc_reg + part_sh;
        end
        if (cmd.finish) begin
            out_count_reg <= count_reg;
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
            out_mean_reg  <= mean_reg;
            out_sum_reg   <= sq_dev_next;
        end
    end

    assign sample_count = out_count_reg;
    assign min_rtt_ns   = out_min_reg;
    assign max_rtt_ns   = out_max_reg;
    assign mean_rtt_q16 = out_mean_reg;
    assign sum_sq_dev   = out_sum_reg;

endmodule

// ===== rtl/lrs_checker.sv =====
// Port-level checker for the latency statistics block, bound to the top level.
`include "latency_running_statistics_top_macros.svh"

module lrs_checker
    import lrs_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [RttW-1:0]   s_rtt_ns,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CountW-1:0] m_sample_count,
    input logic [RttW-1:0]   m_min_rtt_ns,
    input logic [RttW-1:0]   m_max_rtt_ns,
    input logic [MeanW-1:0]  m_mean_rtt_q16,
    input logic [SumW-1:0]   m_sum_sq_dev
);

    logic                                   in_stall;
    logic                                   out_stall;
    logic [CountW+2*RttW+MeanW+SumW-1:0]    out_payload;

    assign in_stall    = s_valid && !s_ready;
    assign out_stall   = m_valid && !m_ready;
    assign out_payload = {m_sample_count, m_min_rtt_ns, m_max_rtt_ns,
                          m_mean_rtt_q16, m_sum_sq_dev};

    `LRS_ASSERT_NEXT(a_in_hold, in_stall, s_valid && $stable(s_rtt_ns), "sample not held")
    `LRS_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(out_payload), "result not held")
    `LRS_ASSERT(a_min_le_max, !m_valid || (m_min_rtt_ns <= m_max_rtt_ns), "min above max")
    `LRS_ASSERT(a_count_nonzero, !m_valid || (m_sample_count != '0), "result with zero count")
    `LRS_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "sample taken while busy")

endmodule

bind latency_running_statistics_top lrs_checker u_lrs_checker (.*);
